/* rtl/dpv_pkg.sv */
package dpv_pkg;

  // register indexes on the configuration channel
  localparam logic [1:0] REG_MAX_NAME_LENGTH  = 2'd0;
  localparam logic [1:0] REG_MAX_LABEL_LENGTH = 2'd1;
  localparam logic [1:0] REG_MIN_LABELS       = 2'd2;

  // register reset values
  localparam logic [7:0] MAX_NAME_LENGTH_RESET  = 8'd253;
  localparam logic [5:0] MAX_LABEL_LENGTH_RESET = 6'd63;
  localparam logic [6:0] MIN_LABELS_RESET       = 7'd2;

  // characters of interest
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_HYPHEN = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // saturation limits
  localparam logic [7:0] LENGTH_MAX = 8'd255;
  localparam logic [6:0] COUNT_MAX  = 7'd127;

  // prefix tracking
  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_STAR  = 3'b010,
    PH_BODY  = 3'b100
  } phase_t;

  // one verdict
  typedef struct packed {
    logic [7:0] name_length;
    logic [6:0] label_total;
    logic       is_wildcard;
    logic       pattern_ok;
  } result_t;

endpackage

/* rtl/domain_pattern_validator_unit.sv */
// Domain pattern validator.
// Input stream (s_*): one raw pattern byte per transaction in s_tdata[7:0],
// s_tlast high on the final byte of a pattern. Output stream (m_*): one
// verdict per pattern, issued for the transaction that carried s_tlast.
// Configuration channel (cfg_*): cfg_index selects max_name_length (0),
// max_label_length (1) or min_labels (2); cfg_ready is always high and
// writes to other indexes are dropped. Write only while no pattern is open.
// Throughput: one byte per cycle while s_tready is high. Each byte updates
// the parser state in the same cycle it is accepted; a verdict is registered
// in the output register, or in the skid register behind a waiting verdict.
// A two-entry output buffer (output register plus skid register) lets the
// input keep flowing while a verdict waits; s_tready drops only when both
// entries hold verdicts, i.e. while the receiver stalls with a full skid.
// Reset (rst, synchronous) clears parser state and both output entries and
// restores the configuration reset values (253, 63, 2). After each verdict
// the parser state returns to its reset value.
module domain_pattern_validator_unit
  import dpv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tlast,   // is_last
  // verdict stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] pattern_ok, [1] is_wildcard, [8:2] label_total,
                                 // [16:9] name_length, [23:17] zero
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // configuration registers
  logic [7:0] max_name_length;
  logic [5:0] max_label_length;
  logic [6:0] min_labels;

  // parser state
  logic [7:0] total_length, total_length_next;
  logic [6:0] label_length, label_length_next;
  logic [6:0] label_count, label_count_next;
  logic [7:0] pending_dots, pending_dots_next;
  logic       last_was_hyphen, last_was_hyphen_next;
  phase_t     phase, phase_next;
  logic       wildcard_seen, wildcard_seen_next;
  logic       rejected, rejected_next;

  // output buffer
  result_t    result, out_reg, skid_reg;
  logic       skid_valid;

  logic       in_fire;
  logic       push;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign in_fire   = s_tvalid && s_tready;
  assign push      = in_fire && s_tlast;
  assign m_tdata   = {7'd0, out_reg};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_length  <= MAX_NAME_LENGTH_RESET;
      max_label_length <= MAX_LABEL_LENGTH_RESET;
      min_labels       <= MIN_LABELS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_NAME_LENGTH:  max_name_length  <= cfg_data;
        REG_MAX_LABEL_LENGTH: max_label_length <= cfg_data[5:0];
        REG_MIN_LABELS:       min_labels       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // byte update and verdict
  always_comb begin
    logic [7:0] b;
    logic [7:0] n;
    logic [7:0] n_lab;
    logic [8:0] len_sum;
    logic [8:0] cnt_sum;
    logic       alnum;
    logic       good;
    logic [6:0] labels;
    logic       ok;

    len_sum = 9'd0;
    cnt_sum = 9'd0;
    n_lab   = 8'd0;
    alnum   = 1'b0;

    total_length_next    = total_length;
    label_length_next    = label_length;
    label_count_next     = label_count;
    pending_dots_next    = pending_dots;
    last_was_hyphen_next = last_was_hyphen;
    phase_next           = phase;
    wildcard_seen_next   = wildcard_seen;
    rejected_next        = rejected;

    b = s_tdata;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      b = b + CASE_OFFSET;
    end
    n = pending_dots;

    if (b == CH_SPACE) begin
      // spaces are dropped
    end else if (b == CH_DOT) begin
      if (pending_dots != LENGTH_MAX) begin
        pending_dots_next = pending_dots + 8'd1;
      end
    end else begin
      // commit held dots
      if (n != 8'd0) begin
        pending_dots_next = 8'd0;
        len_sum = {1'b0, total_length_next} + {1'b0, n};
        if (len_sum[8]) begin
          total_length_next = LENGTH_MAX;
          rejected_next     = 1'b1;
        end else begin
          total_length_next = len_sum[7:0];
        end
        if (phase_next == PH_STAR) begin
          wildcard_seen_next = 1'b1;
          n_lab = n - 8'd1;
          if (n_lab != 8'd0) begin
            rejected_next = 1'b1;
          end
        end else begin
          n_lab = n;
          if (!(label_length_next != 7'd0 &&
                label_length_next <= {1'b0, max_label_length} &&
                !last_was_hyphen_next)) begin
            rejected_next = 1'b1;
          end
          if (n > 8'd1) begin
            rejected_next = 1'b1;
          end
        end
        phase_next = PH_BODY;
        cnt_sum = {2'b00, label_count_next} + {1'b0, n_lab};
        label_count_next     = (cnt_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : cnt_sum[6:0];
        label_length_next    = 7'd0;
        last_was_hyphen_next = 1'b0;
      end
      // count the byte itself
      len_sum = {1'b0, total_length_next} + 9'd1;
      if (len_sum[8]) begin
        total_length_next = LENGTH_MAX;
        rejected_next     = 1'b1;
      end else begin
        total_length_next = len_sum[7:0];
      end
      if (phase_next == PH_START && b == CH_STAR) begin
        // possible wildcard prefix
        phase_next = PH_STAR;
      end else begin
        if (phase_next == PH_STAR) begin
          // star not followed by a dot counts as a label byte
          rejected_next        = 1'b1;
          label_length_next    = 7'd1;
          last_was_hyphen_next = 1'b0;
        end
        phase_next = PH_BODY;
        // label byte checks
        alnum = (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
        if (label_length_next == 7'd0 && b == CH_HYPHEN) begin
          rejected_next = 1'b1;
        end
        if (label_length_next != COUNT_MAX) begin
          label_length_next = label_length_next + 7'd1;
        end
        if (label_length_next > {1'b0, max_label_length}) begin
          rejected_next = 1'b1;
        end
        if (!alnum && b != CH_HYPHEN) begin
          rejected_next = 1'b1;
        end
        last_was_hyphen_next = (b == CH_HYPHEN);
      end
    end

    // verdict from the updated state
    good = label_length_next != 7'd0 &&
           label_length_next <= {1'b0, max_label_length} &&
           !last_was_hyphen_next;
    if (phase_next == PH_BODY) begin
      labels = (label_count_next == COUNT_MAX) ? COUNT_MAX : label_count_next + 7'd1;
      ok     = !rejected_next && good;
    end else begin
      labels = label_count_next;
      ok     = 1'b0;
    end
    if (total_length_next == 8'd0 || total_length_next > max_name_length) begin
      ok = 1'b0;
    end
    if (labels < min_labels) begin
      ok = 1'b0;
    end
    result.pattern_ok  = ok;
    result.is_wildcard = wildcard_seen_next;
    result.label_total = labels;
    result.name_length = total_length_next;

    // pattern end returns to reset
    if (s_tlast) begin
      total_length_next    = 8'd0;
      label_length_next    = 7'd0;
      label_count_next     = 7'd0;
      pending_dots_next    = 8'd0;
      last_was_hyphen_next = 1'b0;
      phase_next           = PH_START;
      wildcard_seen_next   = 1'b0;
      rejected_next        = 1'b0;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_length    <= 8'd0;
      label_length    <= 7'd0;
      label_count     <= 7'd0;
      pending_dots    <= 8'd0;
      last_was_hyphen <= 1'b0;
      phase           <= PH_START;
      wildcard_seen   <= 1'b0;
      rejected        <= 1'b0;
    end else if (in_fire) begin
      total_length    <= total_length_next;
      label_length    <= label_length_next;
      label_count     <= label_count_next;
      pending_dots    <= pending_dots_next;
      last_was_hyphen <= last_was_hyphen_next;
      phase           <= phase_next;
      wildcard_seen   <= wildcard_seen_next;
      rejected        <= rejected_next;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      if (skid_valid) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_reg <= result;
      end else begin
        m_tvalid <= 1'b0;
      end
    end else if (!m_tvalid) begin
      if (push) begin
        out_reg  <= result;
        m_tvalid <= 1'b1;
      end
    end else if (push) begin
      skid_reg   <= result;
      skid_valid <= 1'b1;
    end
  end

  // skid entry is only used behind a waiting verdict
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> m_tvalid)
    else $error("skid entry holds a verdict while output is empty");

  // parser state is back at reset after a pattern ends
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=>
      (total_length == 8'd0 && pending_dots == 8'd0 && phase == PH_START && !rejected))
    else $error("parser state not cleared after last byte");

  // wildcard mark is set only once the body has begun
  assert property (@(posedge clk) disable iff (rst) wildcard_seen |-> (phase == PH_BODY))
    else $error("wildcard marked outside the body");

  // labels are only closed by committed bytes
  assert property (@(posedge clk) disable iff (rst)
    (total_length == 8'd0) |-> (label_count == 7'd0 && label_length == 7'd0))
    else $error("labels counted without any committed length");

  // a stalled verdict is not lost
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled verdict changed");

endmodule
